// ===== sv/fbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types, codes and pattern constants for the blink-code LED sequencer.
// ----------------------------------------------------------------------------
package fbc_pkg;

	// Flash patterns, one 250 ms slot per bit, shifted out MSB first.
	// A one bit means the LED is off.
	localparam logic [31:0] SEQ_PAUSE = 32'hff00_0000;
	localparam logic [31:0] SEQ_IDLE  = 32'h0f00_0000;
	localparam logic [3:0]  NIB_ZERO  = 4'h7;
	localparam logic [3:0]  NIB_ONE   = 4'h1;

	localparam logic [1:0] MODE_OK    = 2'd0;
	localparam logic [1:0] MODE_CODE  = 2'd1;
	localparam logic [1:0] MODE_PAUSE = 2'd2;

	localparam logic ACT_SERVICE = 1'b0;
	localparam logic ACT_TICK    = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] fault_code;
	} in_item_t;

	typedef struct packed {
		logic led_on;
		logic sequence_empty;
	} out_item_t;

	typedef struct packed {
		logic [31:0] flash_bits;
		logic [1:0]  led_mode;
		logic        led_level;
	} seq_state_t;

	// Each code bit becomes four slots: 0111 for a zero, 0001 for a one.
	function automatic logic [31:0] build_pattern(input logic [7:0] code);
		logic [31:0] pat;
		pat = '0;
		for (int i = 0; i < 8; i++) begin
			pat[i*4 +: 4] = code[i] ? NIB_ONE : NIB_ZERO;
		end
		return pat;
	endfunction

endpackage

// ===== sv/fault_blink_code_led_sequencer.sv =====
// ----------------------------------------------------------------------------
// fault_blink_code_led_sequencer
// Status LED blink-code sequencer. Every accepted beat gives one result beat:
// the beat is held in an input register, and the flash register, mode and LED
// level are updated from it together with the result register. The block takes
// one beat per cycle while out_ready does not stall the result register; the
// state update is a single registered step. Tick beats shift the flash register
// out MSB first; service beats reload it only when it is empty, with either the
// idle pattern, the blink code of (fault_prefix OR fault_code), or the 2 s pause
// that follows each code. The configuration port is always ready.
// ----------------------------------------------------------------------------
module fault_blink_code_led_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fbc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fbc_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	logic                valid_s1;
	fbc_pkg::in_item_t   item_s1;
	fbc_pkg::seq_state_t state_q;
	fbc_pkg::seq_state_t state_nxt;
	fbc_pkg::out_item_t  result;
	fbc_pkg::out_item_t  out_q;
	logic                out_valid_q;
	logic [7:0]          prefix_q;
	logic                advance;

	// The input stage moves on whenever the result register is free or being read.
	assign advance   = ~out_valid_q | out_ready;
	assign in_ready  = ~valid_s1 | advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
		end else if (cfg_valid) begin
			prefix_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	fbc_core u_core (
		.cur          (state_q),
		.item         (item_s1),
		.fault_prefix (prefix_q),
		.nxt          (state_nxt),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.flash_bits <= '0;
			state_q.led_mode   <= fbc_pkg::MODE_OK;
			state_q.led_level  <= 1'b0;
			out_valid_q        <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= result;
		end
	end

	// The held result always agrees with the flash register it was built from.
	a_empty_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.sequence_empty == (state_q.flash_bits == '0)))
		else $error("sequence_empty disagrees with the flash register");

	a_tick_level: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && item_s1.action == fbc_pkg::ACT_TICK)
		|=> (out_q.led_on == !$past(state_q.flash_bits[31])))
		else $error("tick beat did not drive the LED from the shifted-out bit");

	a_pause_after_code: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && item_s1.action == fbc_pkg::ACT_SERVICE &&
		 state_q.flash_bits == '0 && state_q.led_mode == fbc_pkg::MODE_CODE)
		|=> (state_q.flash_bits == fbc_pkg::SEQ_PAUSE &&
		     state_q.led_mode == fbc_pkg::MODE_PAUSE))
		else $error("finished code was not followed by the pause");

endmodule

// ===== sv/fbc_core.sv =====
// ----------------------------------------------------------------------------
// fbc_core
// Next-state and result logic for one item of the blink-code sequencer.
// ----------------------------------------------------------------------------
module fbc_core (
	input  fbc_pkg::seq_state_t cur,
	input  fbc_pkg::in_item_t   item,
	input  logic [7:0]          fault_prefix,
	output fbc_pkg::seq_state_t nxt,
	output fbc_pkg::out_item_t  result
);

	logic [7:0] shown_code;

	assign shown_code = fault_prefix | item.fault_code;

	always_comb begin
		nxt = cur;
		if (item.action == fbc_pkg::ACT_TICK) begin
			nxt.led_level  = ~cur.flash_bits[31];
			nxt.flash_bits = {cur.flash_bits[30:0], 1'b0};
		end else if (cur.flash_bits == '0) begin
			// A finished code is always followed by the off pause.
			if (cur.led_mode == fbc_pkg::MODE_CODE) begin
				nxt.flash_bits = fbc_pkg::SEQ_PAUSE;
				nxt.led_mode   = fbc_pkg::MODE_PAUSE;
			end else if (item.fault_code == '0) begin
				nxt.flash_bits = fbc_pkg::SEQ_IDLE;
				nxt.led_mode   = fbc_pkg::MODE_OK;
			end else begin
				nxt.flash_bits = fbc_pkg::build_pattern(shown_code);
				nxt.led_mode   = fbc_pkg::MODE_CODE;
			end
		end
	end

	assign result.led_on         = nxt.led_level;
	assign result.sequence_empty = (nxt.flash_bits == '0);

endmodule
